// ===== design/tlvhp_pkg.sv =====
// Package for the TLV header message parser: beat types, phase and status codes,
// and the header name and version string tables. Depends on nothing.
package tlvhp_pkg;

  localparam int NUM_NAMES  = 10;
  localparam int NAME_SLOTS = 11;
  localparam int VER_LEN    = 5;

  localparam logic [7:0] DESC_END   = 8'h00;
  localparam logic [7:0] DESC_NAME  = 8'h01;
  localparam logic [7:0] DESC_VALUE = 8'h02;

  localparam logic [3:0] KIND_VERSION = 4'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DESC = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_VERSION  = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_DESC    = 10'b00_0000_0010,
    PH_NLEN_HI = 10'b00_0000_0100,
    PH_NLEN_LO = 10'b00_0000_1000,
    PH_NAME    = 10'b00_0001_0000,
    PH_VDESC   = 10'b00_0010_0000,
    PH_VLEN_HI = 10'b00_0100_0000,
    PH_VLEN_LO = 10'b00_1000_0000,
    PH_VALUE   = 10'b01_0000_0000,
    PH_DONE    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } pkt_beat_t;

  typedef struct packed {
    logic [3:0] header_kind;
    logic [7:0] value_data;
    logic       value_valid;
    logic       value_last;
    logic       header_empty;
    logic       message_done;
    logic [1:0] message_status;
  } hdr_beat_t;

  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
    4'd7, 4'd7, 4'd8, 4'd9, 4'd10, 4'd4, 4'd6, 4'd7, 4'd10, 4'd5
  };

  // Names are right-justified in each slot, so the first character sits highest.
  localparam logic [NAME_SLOTS*8-1:0] NAME_ROM [NUM_NAMES] = '{
    "Version", "Request", "Response", "Call-type", "User-agent",
    "INFO", "Reason", "Call-id", "Crypto-key", "Nonce"
  };

  localparam logic [VER_LEN*8-1:0] VER_VALUE = "0.2.3";

  // Character at position pos of name idx; zero past the end of the name.
  function automatic logic [7:0] name_char(input int idx, input logic [3:0] pos);
    logic [7:0] ch;
    int         base;
    ch = 8'h00;
    if (pos < NAME_LEN[idx]) begin
      base = 8 * (int'(NAME_LEN[idx]) - 1 - int'(pos));
      ch   = NAME_ROM[idx][base +: 8];
    end
    return ch;
  endfunction

endpackage

// ===== design/tlv_header_message_parser_top.sv =====
// Top level of the TLV header message parser: one pass per packet byte into a
// result register. Depends on tlvhp_pkg for beat types, codes and name tables.
//
//   channel  direction  payload     handshake
//   pkt      input      pkt_beat_t  pkt_valid / pkt_stall
//   hdr      output     hdr_beat_t  hdr_valid / hdr_stall
//
// Every accepted packet beat yields exactly one result beat, in the cycle after it is accepted.
// The parse state advances at the edge that accepts the packet beat; the result
// goes into the output register at the same edge, so one beat per cycle is
// sustained while the downstream side does not stall the single output register.
// A packet beat is stalled only while the output register is full and the
// downstream side stalls it; when the result drains in the same cycle, a new
// packet beat enters.
// Synchronous reset returns the parser to idle and empties the output register.
module tlv_header_message_parser_top
  import tlvhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pkt_valid,
  output logic      pkt_stall,
  input  pkt_beat_t pkt,
  output logic      hdr_valid,
  input  logic      hdr_stall,
  output hdr_beat_t hdr
);

  phase_t               parse_phase, parse_phase_next;
  logic [15:0]          length_counter, length_counter_next;
  logic [3:0]           name_length, name_length_next;
  logic [3:0]           name_position, name_position_next;
  logic [NUM_NAMES-1:0] candidate_mask, candidate_mask_next;
  logic [3:0]           current_header, current_header_next;
  logic                 version_seen, version_seen_next;
  logic                 version_match, version_match_next;
  logic [7:0]           length_high_byte, length_high_byte_next;

  hdr_beat_t            result;
  logic                 accept;
  logic [15:0]          full_len;
  logic [3:0]           pos_inc;
  logic [NUM_NAMES-1:0] len_mask;
  logic [NUM_NAMES-1:0] char_mask;
  logic [3:0]           first_hit;
  logic [7:0]           ver_char;

  // The output register frees up when its beat is taken in this cycle.
  assign pkt_stall = hdr_valid && hdr_stall;
  assign accept    = pkt_valid && !pkt_stall;

  assign full_len = {length_high_byte, pkt.data_byte};
  assign pos_inc  = name_position + 4'd1;

  // Candidates by name length, and candidates surviving the current name byte.
  always_comb begin
    for (int i = 0; i < NUM_NAMES; i++) begin
      len_mask[i]  = (full_len == {12'd0, NAME_LEN[i]});
      char_mask[i] = candidate_mask[i] && (name_position < 4'(NAME_SLOTS))
                     && (name_char(i, name_position) == pkt.data_byte);
    end
  end

  // The lowest surviving name wins when the name is complete.
  always_comb begin
    first_hit = 4'd0;
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      if (char_mask[i]) begin
        first_hit = 4'(i + 1);
      end
    end
  end

  // Expected version character for the remaining count; valid for counts 1 to 5.
  always_comb begin
    ver_char = 8'h00;
    if (length_counter >= 16'd1 && length_counter <= 16'(VER_LEN)) begin
      ver_char = VER_VALUE[8 * (length_counter[2:0] - 3'd1) +: 8];
    end
  end

  always_comb begin
    parse_phase_next      = parse_phase;
    length_counter_next   = length_counter;
    name_length_next      = name_length;
    name_position_next    = name_position;
    candidate_mask_next   = candidate_mask;
    current_header_next   = current_header;
    version_seen_next     = version_seen;
    version_match_next    = version_match;
    length_high_byte_next = length_high_byte;
    result                = '0;

    if (pkt.packet_start) begin
      // The marker byte is skipped and the message state starts over.
      parse_phase_next      = PH_DESC;
      length_counter_next   = '0;
      name_length_next      = '0;
      name_position_next    = '0;
      candidate_mask_next   = '0;
      current_header_next   = '0;
      version_seen_next     = 1'b0;
      version_match_next    = 1'b0;
      length_high_byte_next = '0;
    end else begin
      unique case (parse_phase)
        PH_DESC: begin
          if (pkt.data_byte == DESC_END) begin
            result.message_done   = 1'b1;
            result.message_status = (version_seen && version_match) ? ST_OK : ST_VERSION;
            parse_phase_next      = PH_DONE;
          end else if (pkt.data_byte == DESC_NAME) begin
            parse_phase_next = PH_NLEN_HI;
          end else begin
            result.message_done   = 1'b1;
            result.message_status = ST_BAD_DESC;
            parse_phase_next      = PH_DONE;
          end
        end
        PH_NLEN_HI: begin
          length_high_byte_next = pkt.data_byte;
          parse_phase_next      = PH_NLEN_LO;
        end
        PH_NLEN_LO: begin
          // Only lengths of known names are kept, so four bits hold the length.
          name_length_next    = full_len[3:0];
          candidate_mask_next = len_mask;
          name_position_next  = '0;
          if (len_mask == '0) begin
            result.message_done   = 1'b1;
            result.message_status = ST_UNKNOWN;
            parse_phase_next      = PH_DONE;
          end else begin
            parse_phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          candidate_mask_next = char_mask;
          name_position_next  = pos_inc;
          if (char_mask == '0) begin
            result.message_done   = 1'b1;
            result.message_status = ST_UNKNOWN;
            parse_phase_next      = PH_DONE;
          end else if (pos_inc >= name_length) begin
            current_header_next = first_hit;
            parse_phase_next    = PH_VDESC;
          end
        end
        PH_VDESC: begin
          if (pkt.data_byte == DESC_VALUE) begin
            parse_phase_next = PH_VLEN_HI;
          end else begin
            result.message_done   = 1'b1;
            result.message_status = ST_BAD_DESC;
            parse_phase_next      = PH_DONE;
          end
        end
        PH_VLEN_HI: begin
          length_high_byte_next = pkt.data_byte;
          parse_phase_next      = PH_VLEN_LO;
        end
        PH_VLEN_LO: begin
          length_counter_next = full_len;
          // A later version header replaces what an earlier one left.
          if (current_header == KIND_VERSION) begin
            version_seen_next  = 1'b1;
            version_match_next = (full_len == 16'(VER_LEN));
          end
          if (full_len == '0) begin
            result.header_kind  = current_header;
            result.header_empty = 1'b1;
            parse_phase_next    = PH_DESC;
          end else begin
            parse_phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          result.header_kind = current_header;
          result.value_data  = pkt.data_byte;
          result.value_valid = 1'b1;
          result.value_last  = (length_counter == 16'd1);
          if (current_header == KIND_VERSION && version_match) begin
            if (length_counter > 16'(VER_LEN) || length_counter == '0
                || ver_char != pkt.data_byte) begin
              version_match_next = 1'b0;
            end
          end
          length_counter_next = length_counter - 16'd1;
          if (length_counter == 16'd1) begin
            parse_phase_next = PH_DESC;
          end
        end
        PH_IDLE, PH_DONE: begin
          // Bytes are ignored until the next start flag.
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_IDLE;
      length_counter   <= '0;
      name_length      <= '0;
      name_position    <= '0;
      candidate_mask   <= '0;
      current_header   <= '0;
      version_seen     <= 1'b0;
      version_match    <= 1'b0;
      length_high_byte <= '0;
      hdr_valid        <= 1'b0;
    end else begin
      if (accept) begin
        parse_phase      <= parse_phase_next;
        length_counter   <= length_counter_next;
        name_length      <= name_length_next;
        name_position    <= name_position_next;
        candidate_mask   <= candidate_mask_next;
        current_header   <= current_header_next;
        version_seen     <= version_seen_next;
        version_match    <= version_match_next;
        length_high_byte <= length_high_byte_next;
        hdr_valid        <= 1'b1;
      end else if (!hdr_stall) begin
        hdr_valid <= 1'b0;
      end
    end
  end

  // The result payload holds while stalled, since no packet beat is taken then.
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= result;
    end
  end

endmodule
